// ===== hdl/ipa_pkg.sv =====
// Shared types, codes and defaults for the ID pool allocator.
`timescale 1ns / 1ps

package ipa_pkg;

    localparam int NUM_SLOTS_DEF = 32;

    localparam int MASK_W = 32;
    localparam int IDS_W = 6;
    localparam int SLOT_W = 5;
    localparam int REQ_W = 2;
    localparam int ST_W = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [MASK_W-1:0] MASK_RESET = '1;
    localparam logic [IDS_W-1:0] IDS_RESET = IDS_W'(32);

    localparam logic [CFG_IDX_W-1:0] REG_AVAILABLE_MASK = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IDS_IN_USE = CFG_IDX_W'(1);

    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TAKE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_INIT = 2'd3;

    localparam logic [ST_W-1:0] ST_NOT_AVAIL = 2'd0;
    localparam logic [ST_W-1:0] ST_FREE = 2'd1;
    localparam logic [ST_W-1:0] ST_TAKEN = 2'd2;
    localparam logic [ST_W-1:0] ST_FREED = 2'd3;

    typedef struct packed {
        logic [MASK_W-1:0] available_mask;
        logic [IDS_W-1:0] ids_in_use;
    } pool_cfg_t;

endpackage

// ===== hdl/ipa_slot_ram.sv =====
// Slot state memory: one write port, one registered read port.
`timescale 1ns / 1ps

module ipa_slot_ram
    import ipa_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF,
    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  logic            aclk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  logic [ST_W-1:0] wdata,
    input  logic [AW-1:0]   raddr,
    output logic [ST_W-1:0] rdata
);

    logic [ST_W-1:0] mem [NUM_SLOTS];
    logic [ST_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/ipa_seq.sv =====
// Request sequencer: pool sweep, pointer and hint probe, slot scan and result register.
`timescale 1ns / 1ps

module ipa_seq
    import ipa_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF,
    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
    localparam int CW = $clog2(NUM_SLOTS + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  pool_cfg_t         cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [REQ_W-1:0]  s_req_type,
    input  logic [SLOT_W-1:0] s_slot_id,
    input  logic              s_hint_valid,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [SLOT_W-1:0] m_granted_id,
    output logic              m_ok,
    output logic              ram_we,
    output logic [AW-1:0]     ram_waddr,
    output logic [ST_W-1:0]   ram_wdata,
    output logic [AW-1:0]     ram_raddr,
    input  logic [ST_W-1:0]   ram_rdata
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_PTR   = 3'd3;
    localparam logic [2:0] S_PCHK  = 3'd4;
    localparam logic [2:0] S_SCAN  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              init_resp_reg, init_resp_next;
    logic [AW-1:0]     rr_reg, rr_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     pend_idx_reg, pend_idx_next;
    logic              freed_hit_reg, freed_hit_next;
    logic [AW-1:0]     freed_idx_reg, freed_idx_next;
    logic              free_hit_reg, free_hit_next;
    logic [AW-1:0]     free_idx_reg, free_idx_next;
    logic [REQ_W-1:0]  req_reg, req_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              hint_reg, hint_next;
    logic [AW-1:0]     res_id_reg, res_id_next;
    logic              res_ok_reg, res_ok_next;
    logic              m_valid_reg, m_valid_next;
    logic [SLOT_W-1:0] m_id_reg, m_id_next;
    logic              m_ok_reg, m_ok_next;

    logic [CW-1:0]     n_act;
    logic [AW-1:0]     ptr_wrap;
    logic              slot_in_range;
    logic              hint_in_range;
    logic              clr_mask_bit;
    logic [ST_W-1:0]   clr_state;

    always_comb begin
        if (cfg.ids_in_use == '0) begin
            n_act = CW'(1);
        end else if (int'(cfg.ids_in_use) > NUM_SLOTS) begin
            n_act = CW'(NUM_SLOTS);
        end else begin
            n_act = CW'(cfg.ids_in_use);
        end
    end

    assign ptr_wrap = (CW'(rr_reg) >= n_act) ? '0 : rr_reg;
    assign slot_in_range = int'(slot_reg) < NUM_SLOTS;
    assign hint_in_range = int'(slot_reg) < int'(n_act);
    assign clr_mask_bit = ((cfg.available_mask >> cnt_reg[AW-1:0]) & MASK_W'(1)) != '0;

    always_comb begin
        if (cnt_reg[AW-1:0] == '0) begin
            clr_state = ST_TAKEN;
        end else if ((cnt_reg < n_act) && clr_mask_bit) begin
            clr_state = ST_FREE;
        end else begin
            clr_state = ST_NOT_AVAIL;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        init_resp_next = init_resp_reg;
        rr_next        = rr_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        freed_hit_next = freed_hit_reg;
        freed_idx_next = freed_idx_reg;
        free_hit_next  = free_hit_reg;
        free_idx_next  = free_idx_reg;
        req_next       = req_reg;
        slot_next      = slot_reg;
        hint_next      = hint_reg;
        res_id_next    = res_id_reg;
        res_ok_next    = res_ok_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = ST_TAKEN;
        ram_raddr      = '0;

        case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[AW-1:0];
                ram_wdata = clr_state;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CW'(NUM_SLOTS - 1)) begin
                    rr_next = (n_act > CW'(1)) ? AW'(1) : '0;
                    if (init_resp_reg) begin
                        res_id_next = '0;
                        res_ok_next = 1'b1;
                        state_next  = S_DONE;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    req_next  = s_req_type;
                    slot_next = s_slot_id;
                    hint_next = s_hint_valid;
                    case (s_req_type)
                        REQ_ALLOC: state_next = S_PTR;
                        REQ_INIT: begin
                            cnt_next       = '0;
                            init_resp_next = 1'b1;
                            state_next     = S_CLEAR;
                        end
                        default: state_next = S_EXEC;
                    endcase
                end
            end
            S_EXEC: begin
                res_id_next = '0;
                res_ok_next = slot_in_range;
                ram_we      = slot_in_range;
                ram_waddr   = AW'(slot_reg);
                ram_wdata   = (req_reg == REQ_FREE) ? ST_FREED : ST_TAKEN;
                state_next  = S_DONE;
            end
            S_PTR: begin
                rr_next        = ptr_wrap;
                cnt_next       = '0;
                freed_hit_next = 1'b0;
                free_hit_next  = 1'b0;
                if (!hint_reg) begin
                    ram_raddr  = ptr_wrap;
                    state_next = S_PCHK;
                end else if (hint_in_range) begin
                    ram_raddr  = AW'(slot_reg);
                    state_next = S_PCHK;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_PCHK: begin
                if (!hint_reg && ram_rdata != ST_TAKEN) begin
                    ram_we      = 1'b1;
                    ram_waddr   = rr_reg;
                    res_id_next = rr_reg;
                    res_ok_next = 1'b1;
                    rr_next     = ((CW'(rr_reg) + 1'b1) >= n_act) ? '0 : rr_reg + 1'b1;
                    state_next  = S_DONE;
                end else if (hint_reg && (ram_rdata == ST_FREE || ram_rdata == ST_FREED)) begin
                    ram_we      = 1'b1;
                    ram_waddr   = AW'(slot_reg);
                    res_id_next = AW'(slot_reg);
                    res_ok_next = 1'b1;
                    state_next  = S_DONE;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (cnt_reg < n_act) begin
                    ram_raddr     = cnt_reg[AW-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = cnt_reg[AW-1:0];
                    cnt_next      = cnt_reg + 1'b1;
                end
                if (pend_reg) begin
                    if (ram_rdata == ST_FREED && !freed_hit_reg) begin
                        freed_hit_next = 1'b1;
                        freed_idx_next = pend_idx_reg;
                    end
                    if (ram_rdata == ST_FREE && !free_hit_reg) begin
                        free_hit_next = 1'b1;
                        free_idx_next = pend_idx_reg;
                    end
                end
                if (cnt_reg >= n_act && !pend_reg) begin
                    state_next = S_DONE;
                    if (freed_hit_reg) begin
                        ram_we      = 1'b1;
                        ram_waddr   = freed_idx_reg;
                        res_id_next = freed_idx_reg;
                        res_ok_next = 1'b1;
                    end else if (free_hit_reg) begin
                        ram_we      = 1'b1;
                        ram_waddr   = free_idx_reg;
                        res_id_next = free_idx_reg;
                        res_ok_next = 1'b1;
                    end else begin
                        res_id_next = '0;
                        res_ok_next = 1'b0;
                    end
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_id_next    = m_id_reg;
        m_ok_next    = m_ok_reg;
        if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
            m_valid_next = 1'b1;
            m_id_next    = SLOT_W'(res_id_reg);
            m_ok_next    = res_ok_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            init_resp_reg <= 1'b0;
            rr_reg        <= '0;
            pend_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            init_resp_reg <= init_resp_next;
            rr_reg        <= rr_next;
            pend_reg      <= pend_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_idx_reg  <= pend_idx_next;
        freed_hit_reg <= freed_hit_next;
        freed_idx_reg <= freed_idx_next;
        free_hit_reg  <= free_hit_next;
        free_idx_reg  <= free_idx_next;
        req_reg       <= req_next;
        slot_reg      <= slot_next;
        hint_reg      <= hint_next;
        res_id_reg    <= res_id_next;
        res_ok_reg    <= res_ok_next;
        m_id_reg      <= m_id_next;
        m_ok_reg      <= m_ok_next;
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_granted_id = m_id_reg;
    assign m_ok         = m_ok_reg;

    assert property (@(posedge aclk) !aresetn |=> state_reg == S_CLEAR)
        else $error("sweep does not follow reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> state_reg != S_IDLE && state_reg != S_DONE)
        else $error("pool written while no transaction is in flight");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && !res_ok_reg) |->
        (req_reg == REQ_ALLOC || !slot_in_range))
        else $error("failure reported for a request that cannot fail");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && cnt_reg < n_act) |=> pend_reg)
        else $error("scan read lost");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PCHK && !hint_reg) |-> CW'(rr_reg) < n_act)
        else $error("round-robin pointer outside active pool");

endmodule

// ===== hdl/id_pool_allocator_with_affinity_core.sv =====
// ID pool allocator with affinity: top level with configuration registers.
`timescale 1ns / 1ps

// One request enters at a time and gives one result. Free and mark-taken pass
// through S_EXEC to S_DONE, an allocate that hits the pointer or hint slot
// through S_PTR and S_PCHK, and an allocate that falls back to scanning reads
// all n active entries in S_SCAN, where n is ids_in_use limited to 1..NUM_SLOTS:
// the scan reads the slot state memory one entry per cycle through its single
// read port. Initialise and reset rewrite every one of the NUM_SLOTS entries,
// one per cycle, and s_ready stays low during that sweep. The next request may
// be taken while a result still waits on m_ready. A written available_mask
// reaches the pool only at the next initialise or reset; ids_in_use acts at once.
module id_pool_allocator_with_affinity_core
    import ipa_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [REQ_W-1:0]      s_req_type,
    input  logic [SLOT_W-1:0]     s_slot_id,
    input  logic                  s_hint_valid,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SLOT_W-1:0]     m_granted_id,
    output logic                  m_ok
);

    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    pool_cfg_t       cfg_reg, cfg_next;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [ST_W-1:0] ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [ST_W-1:0] ram_rdata;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_AVAILABLE_MASK: cfg_next.available_mask = MASK_W'(cfg_wdata);
                REG_IDS_IN_USE:     cfg_next.ids_in_use = cfg_wdata[IDS_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.available_mask <= MASK_RESET;
            cfg_reg.ids_in_use     <= IDS_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ipa_seq #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_slot_id    (s_slot_id),
        .s_hint_valid (s_hint_valid),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_granted_id (m_granted_id),
        .m_ok         (m_ok),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata)
    );

    ipa_slot_ram #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
